FILE: sv/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg: shared types, constants and arithmetic helpers
// Fixed-point constants, Horner division tables and rounding helpers for the
// haversine great-circle distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

  // field widths
  localparam int unsigned LAT_W    = 24;
  localparam int unsigned LON_W    = 25;
  localparam int unsigned RADIUS_W = 13;
  localparam int unsigned DIST_W   = 23;
  localparam int unsigned HALF_W   = 17;

  // half angle resolution in bits below one radian
  localparam int unsigned ANGLE_FRAC_BITS = 16;

  // Q30 values up to pi/2 need 31 bits
  localparam int unsigned QW = 31;
  localparam int unsigned MAG_W = 24;   // folded angle magnitude, 2^-17 degree

  localparam logic [63:0] PI_Q60      = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] DEG_RAD_K64 = (PI_Q60 + (64'd90 << 20)) / (64'd180 << 20);
  localparam logic [34:0] DEG_RAD_K   = DEG_RAD_K64[34:0];
  localparam logic [63:0] HALF_PI_64  = (PI_Q60 + (64'd1 << 30)) >> 31;
  localparam logic [QW-1:0] HALF_PI_Q = HALF_PI_64[QW-1:0];
  localparam logic [QW-1:0] ONE_Q     = 31'h4000_0000;

  localparam logic [26:0] QUARTER_TURN = 27'd11796480;
  localparam logic [26:0] HALF_TURN    = 27'd23592960;
  localparam logic signed [LAT_W-1:0] LAT_LIMIT = 24'sd5898240;
  localparam logic signed [LON_W-1:0] LON_LIMIT = 25'sd11796480;

  localparam logic [HALF_W-1:0] HALF_MAX = '1;

  // sine pipeline shape: Horner steps, two stages each, plus entry and exit
  localparam int unsigned SINE_STEPS = 7;
  localparam int unsigned SINE_LAT   = 2 * SINE_STEPS + 2;
  localparam int unsigned SEARCH_STEPS = 31;

  // term divisors 210,156,110,72,42,20,6 as reciprocal, shift and half
  localparam logic [7:0] HORNER_HALF [SINE_STEPS] = '{
    8'd105, 8'd78, 8'd55, 8'd36, 8'd21, 8'd10, 8'd3
  };
  localparam logic [5:0] HORNER_SHIFT [SINE_STEPS] = '{
    6'd41, 6'd41, 6'd40, 6'd40, 6'd39, 6'd38, 6'd36
  };
  localparam logic [33:0] HORNER_RECIP [SINE_STEPS] = '{
    34'(((64'd1 << 41) + 64'd209) / 64'd210),
    34'(((64'd1 << 41) + 64'd155) / 64'd156),
    34'(((64'd1 << 40) + 64'd109) / 64'd110),
    34'(((64'd1 << 40) + 64'd71) / 64'd72),
    34'(((64'd1 << 39) + 64'd41) / 64'd42),
    34'(((64'd1 << 38) + 64'd19) / 64'd20),
    34'(((64'd1 << 36) + 64'd5) / 64'd6)
  };

  // Q30 product, rounded half up
  function automatic logic [35:0] mul_q30(input logic [32:0] a, input logic [32:0] b);
    logic [65:0] p;
    p = 66'(a) * 66'(b) + (66'd1 << 29);
    return p[65:30];
  endfunction

  // magnitude of an angle in 2^-17 degree, folded into [0, 90] degrees
  function automatic logic [MAG_W-1:0] fold_angle(input logic signed [26:0] a);
    logic [26:0] m;
    m = a[26] ? 27'(-a) : 27'(a);
    if (m > HALF_TURN) m = HALF_TURN;
    if (m > QUARTER_TURN) m = HALF_TURN - m;
    return m[MAG_W-1:0];
  endfunction

  // 2^-17 degree to Q30 radians, rounded half up
  function automatic logic [QW-1:0] deg_to_rad(input logic [MAG_W-1:0] m);
    logic [58:0] p;
    p = 59'(m) * 59'(DEG_RAD_K) + (59'd1 << 26);
    return p[57:27];
  endfunction

endpackage

FILE: sv/gcd_if.sv
// ----------------------------------------------------------------------------
// gcd_if: channel interfaces
// Valid/ready channels for point pairs, results and the radius register.
// ----------------------------------------------------------------------------
interface gcd_in_if import gcd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] lat_a;
  logic signed [LON_W-1:0] lon_a;
  logic signed [LAT_W-1:0] lat_b;
  logic signed [LON_W-1:0] lon_b;

  modport source(output valid, lat_a, lon_a, lat_b, lon_b, input ready);
  modport sink(input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface gcd_out_if import gcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_out;
  logic [HALF_W-1:0] half_angle;

  modport source(output valid, distance_out, half_angle, input ready);
  modport sink(input valid, distance_out, half_angle, output ready);
endinterface

interface gcd_cfg_if import gcd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RADIUS_W-1:0] radius_km;

  modport source(output valid, radius_km, input ready);
  modport sink(input valid, radius_km, output ready);
endinterface

FILE: sv/great_circle_distance.sv
// ----------------------------------------------------------------------------
// great_circle_distance: haversine distance pipeline
// Distance and half central angle between two points given in fixed-point
// degrees, one point pair per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : point pairs (lat_a, lon_a, lat_b, lon_b), 2^-16 degree, signed.
//           Out-of-range coordinates are clamped to +-90 / +-180 degrees.
//   out_o : distance_out (2^-8 km) and half_angle (2^-16 rad), one result
//           per input transaction, in order.
//   cfg_i : radius_km, always ready; write only while no pair is in flight.
// The pipeline holds 3 front-end stages, a 16-stage sine for the
// haversine terms, 3 combine stages, 31 search steps of 17 stages each
// (one bit of theta per step, each with its own sine pipeline) and the
// output register. Throughput is one transaction per cycle unless stalled.
// The whole pipeline shares one enable: it advances when the output
// register is empty or being taken, so a stalled receiver holds every
// stage and in_i.ready follows out_o.ready while a result is waiting.
// Reset empties the pipeline and sets the radius to 6371 km.
// ----------------------------------------------------------------------------
module great_circle_distance import gcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  gcd_in_if.sink    in_i,
  gcd_out_if.source out_o,
  gcd_cfg_if.sink   cfg_i
);

  logic en;
  logic v_out_q;

  assign en         = !v_out_q || out_o.ready;
  assign in_i.ready = en;

  // radius register
  logic [RADIUS_W-1:0] radius_q;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 13'd6371;
    end else if (cfg_i.valid) begin
      radius_q <= cfg_i.radius_km;
    end
  end

  // stage 1: clamp coordinates
  logic                    v1_q;
  logic signed [LAT_W-1:0] la_q, lb_q;
  logic signed [LON_W-1:0] oa_q, ob_q;

  function automatic logic signed [LAT_W-1:0] clamp_lat(input logic signed [LAT_W-1:0] v);
    if (v > LAT_LIMIT) return LAT_LIMIT;
    if (v < -LAT_LIMIT) return -LAT_LIMIT;
    return v;
  endfunction

  function automatic logic signed [LON_W-1:0] clamp_lon(input logic signed [LON_W-1:0] v);
    if (v > LON_LIMIT) return LON_LIMIT;
    if (v < -LON_LIMIT) return -LON_LIMIT;
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      la_q <= clamp_lat(in_i.lat_a);
      oa_q <= clamp_lon(in_i.lon_a);
      lb_q <= clamp_lat(in_i.lat_b);
      ob_q <= clamp_lon(in_i.lon_b);
    end
  end

  // stage 2: differences, cosine complements, folding
  logic             v2_q;
  logic [MAG_W-1:0] m_q [4];
  logic signed [26:0] dlat, dlon, cpa, cpb;
  logic [26:0]        abs_la, abs_lb;

  assign dlat   = 27'(lb_q) - 27'(la_q);
  assign dlon   = 27'(ob_q) - 27'(oa_q);
  assign abs_la = la_q[LAT_W-1] ? 27'(-27'(la_q)) : 27'(la_q);
  assign abs_lb = lb_q[LAT_W-1] ? 27'(-27'(lb_q)) : 27'(lb_q);
  assign cpa    = $signed(QUARTER_TURN - (abs_la << 1));
  assign cpb    = $signed(QUARTER_TURN - (abs_lb << 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q[0] <= fold_angle(dlat);
      m_q[1] <= fold_angle(dlon);
      m_q[2] <= fold_angle(cpa);
      m_q[3] <= fold_angle(cpb);
    end
  end

  // stage 3: to radians
  logic          v3_q;
  logic [QW-1:0] r_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) r_q[i] <= deg_to_rad(m_q[i]);
    end
  end

  // sines of half differences and cosines of latitudes
  logic [QW-1:0] sn [4];

  for (genvar i = 0; i < 4; i++) begin : g_sine
    gcd_sine u_sine (
      .clk_i (clk_i),
      .en_i  (en),
      .r_i   (r_q[i]),
      .s_o   (sn[i])
    );
  end

  logic sv_q [SINE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SINE_LAT; i++) sv_q[i] <= 1'b0;
    end else if (en) begin
      sv_q[0] <= v3_q;
      for (int i = 1; i < SINE_LAT; i++) sv_q[i] <= sv_q[i-1];
    end
  end

  // combine 1: squares and cosine product
  logic          vc1_q, vc2_q, vc3_q;
  logic [QW-1:0] uu_q, vv_q, c_q, uu2_q, cvv_q, h_q;
  logic [35:0]   uu_f, vv_f, c_f, cvv_f;
  logic [31:0]   h_sum;

  assign uu_f  = mul_q30(33'(sn[0]), 33'(sn[0]));
  assign vv_f  = mul_q30(33'(sn[1]), 33'(sn[1]));
  assign c_f   = mul_q30(33'(sn[2]), 33'(sn[3]));
  assign cvv_f = mul_q30(33'(c_q), 33'(vv_q));
  assign h_sum = 32'(uu2_q) + 32'(cvv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc1_q <= 1'b0;
      vc2_q <= 1'b0;
      vc3_q <= 1'b0;
    end else if (en) begin
      vc1_q <= sv_q[SINE_LAT-1];
      vc2_q <= vc1_q;
      vc3_q <= vc2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      uu_q  <= uu_f[QW-1:0];
      vv_q  <= vv_f[QW-1:0];
      c_q   <= c_f[QW-1:0];
      // combine 2: weight longitude term by the cosine product
      uu2_q <= uu_q;
      cvv_q <= cvv_f[QW-1:0];
      // combine 3: haversine term, capped at one
      h_q   <= (h_sum > 32'(ONE_Q)) ? ONE_Q : h_sum[QW-1:0];
    end
  end

  // bitwise inverse-sine search, most significant bit first
  logic          sv_c [SEARCH_STEPS+1];
  logic [QW-1:0] th_c [SEARCH_STEPS+1];
  logic [QW-1:0] h_c  [SEARCH_STEPS+1];

  assign sv_c[0] = vc3_q;
  assign th_c[0] = '0;
  assign h_c[0]  = h_q;

  for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_search
    gcd_srch_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .bit_i   (5'(SEARCH_STEPS - 1 - i)),
      .valid_i (sv_c[i]),
      .theta_i (th_c[i]),
      .h_i     (h_c[i]),
      .valid_o (sv_c[i+1]),
      .theta_o (th_c[i+1]),
      .h_o     (h_c[i+1])
    );
  end

  // output register: scale and round
  logic [43:0]         dist_p;
  logic [31:0]         half_p;
  logic [31:0]         half_s;
  logic [DIST_W-1:0]   dist_q;
  logic [HALF_W-1:0]   half_q;
  logic [QW-1:0]       theta;

  assign theta  = th_c[SEARCH_STEPS];
  assign dist_p = 44'(radius_q) * 44'(theta) + (44'd1 << 20);
  assign half_p = 32'(theta) + (32'd1 << (29 - ANGLE_FRAC_BITS));
  assign half_s = half_p >> (30 - ANGLE_FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_out_q <= 1'b0;
    end else if (en) begin
      v_out_q <= sv_c[SEARCH_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= dist_p[43:21];
      half_q <= (half_s > 32'(HALF_MAX)) ? HALF_MAX : half_s[HALF_W-1:0];
    end
  end

  assign out_o.valid        = v_out_q;
  assign out_o.distance_out = dist_q;
  assign out_o.half_angle   = half_q;

endmodule

FILE: sv/gcd_sine.sv
// ----------------------------------------------------------------------------
// gcd_sine: pipelined Q30 sine
// Sine of an angle in [0, pi/2] by a Horner series to x^15, one multiply
// stage and one divide-by-constant stage per term.
// ----------------------------------------------------------------------------
module gcd_sine import gcd_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [QW-1:0] r_i,
  output logic [QW-1:0] s_o
);

  logic [31:0]   x2_q [2*SINE_STEPS-1];
  logic [QW-1:0] r_q  [2*SINE_STEPS+1];
  logic [32:0]   t_q  [SINE_STEPS];
  logic [QW-1:0] s_q  [SINE_STEPS];
  logic [QW-1:0] s_out_q;

  // entry: clamp and square
  logic [QW-1:0] r_clamp;
  logic [35:0]   x2_full;
  assign r_clamp = (r_i > HALF_PI_Q) ? HALF_PI_Q : r_i;
  assign x2_full = mul_q30(33'(r_clamp), 33'(r_clamp));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q[0] <= x2_full[31:0];
      r_q[0]  <= r_clamp;
    end
  end

  // Horner terms
  for (genvar j = 0; j < SINE_STEPS; j++) begin : g_term
    logic [QW-1:0] s_cur;
    logic [35:0]   t_full;
    logic [33:0]   n;
    logic [67:0]   p;
    logic [67:0]   q_full;
    logic [33:0]   q;
    logic [QW-1:0] s_d;

    if (j == 0) begin : g_first
      assign s_cur = ONE_Q;
    end else begin : g_rest
      assign s_cur = s_q[j-1];
    end

    assign t_full = mul_q30(33'(x2_q[2*j]), 33'(s_cur));

    // multiply stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[j]       <= t_full[32:0];
        r_q[2*j+1]   <= r_q[2*j];
      end
    end

    // rounded divide by the term constant, then 1 - t
    assign n      = 34'(t_q[j]) + 34'(HORNER_HALF[j]);
    assign p      = 68'(n) * 68'(HORNER_RECIP[j]);
    assign q_full = p >> HORNER_SHIFT[j];
    assign q      = q_full[33:0];
    assign s_d    = (q >= 34'(ONE_Q)) ? '0 : (ONE_Q - q[QW-1:0]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[j]     <= s_d;
        r_q[2*j+2] <= r_q[2*j+1];
      end
    end

    // carry x^2 to the next term
    if (j < SINE_STEPS - 1) begin : g_x2
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x2_q[2*j+1] <= x2_q[2*j];
          x2_q[2*j+2] <= x2_q[2*j+1];
        end
      end
    end
  end

  // exit: x times series, capped at one
  logic [35:0] res;
  assign res = mul_q30(33'(r_q[2*SINE_STEPS]), 33'(s_q[SINE_STEPS-1]));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_out_q <= (res > 36'(ONE_Q)) ? ONE_Q : res[QW-1:0];
    end
  end

  assign s_o = s_out_q;

endmodule

FILE: sv/gcd_srch_step.sv
// ----------------------------------------------------------------------------
// gcd_srch_step: one bit of the inverse-sine search
// Tries setting one bit of theta and keeps it when the candidate is within pi/2 and sin^2 stays within h.
// ----------------------------------------------------------------------------
module gcd_srch_step import gcd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [4:0]    bit_i,
  input  logic          valid_i,
  input  logic [QW-1:0] theta_i,
  input  logic [QW-1:0] h_i,
  output logic          valid_o,
  output logic [QW-1:0] theta_o,
  output logic [QW-1:0] h_o
);

  logic [QW-1:0] cand;
  logic          skip;
  logic [QW-1:0] s;

  assign cand = theta_i | (31'd1 << bit_i);
  assign skip = cand > HALF_PI_Q;

  gcd_sine u_sine (
    .clk_i (clk_i),
    .en_i  (en_i),
    .r_i   (cand),
    .s_o   (s)
  );

  // sideband delay matching the sine pipeline
  logic          v_q     [SINE_LAT];
  logic [QW-1:0] theta_q [SINE_LAT];
  logic [QW-1:0] h_q     [SINE_LAT];
  logic          skip_q  [SINE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SINE_LAT; i++) v_q[i] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < SINE_LAT; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      theta_q[0] <= theta_i;
      h_q[0]     <= h_i;
      skip_q[0]  <= skip;
      for (int i = 1; i < SINE_LAT; i++) begin
        theta_q[i] <= theta_q[i-1];
        h_q[i]     <= h_q[i-1];
        skip_q[i]  <= skip_q[i-1];
      end
    end
  end

  // square and compare
  logic [35:0]   sq;
  logic          take;
  logic [QW-1:0] theta_d;
  logic          v_out_q;
  logic [QW-1:0] theta_out_q;
  logic [QW-1:0] h_out_q;

  assign sq      = mul_q30(33'(s), 33'(s));
  assign take    = !skip_q[SINE_LAT-1] && (sq <= 36'(h_q[SINE_LAT-1]));
  assign theta_d = take ? (theta_q[SINE_LAT-1] | (31'd1 << bit_i)) : theta_q[SINE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_out_q <= 1'b0;
    end else if (en_i) begin
      v_out_q <= v_q[SINE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      theta_out_q <= theta_d;
      h_out_q     <= h_q[SINE_LAT-1];
    end
  end

  assign valid_o = v_out_q;
  assign theta_o = theta_out_q;
  assign h_o     = h_out_q;

endmodule
